FILE: src/wtt_pkg.sv
package wtt_pkg;

    // Default sizes of the path store and of one coordinate.
    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths.
    localparam int INDEX_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int EXT_W      = 16;

    // Input item kinds.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_POSE  = 1'b1;

    // Path modes. Any code above PM_KEY selects the external target.
    localparam logic [1:0] PM_INTERP = 2'd0;
    localparam logic [1:0] PM_KEY    = 2'd1;
    localparam logic [1:0] PM_EXT    = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATH_MODE   = 3'd0,
        CFG_PATH_POINTS = 3'd1,
        CFG_LOOKAHEAD   = 3'd2,
        CFG_RADIUS      = 3'd3,
        CFG_EXT_X       = 3'd4,
        CFG_EXT_Y       = 3'd5
    } t_cfg_reg;

    // Control that travels with one waypoint through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_tag;

endpackage

FILE: src/wtt_in_if.sv
interface wtt_in_if #(
    parameter int COORD_BITS = wtt_pkg::COORD_BITS_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [wtt_pkg::INDEX_W-1:0]       point_index;
    logic signed [COORD_BITS-1:0]      pos_x;
    logic signed [COORD_BITS-1:0]      pos_y;

    modport source (output valid, mode, point_index, pos_x, pos_y, input ready);
    modport sink (input valid, mode, point_index, pos_x, pos_y, output ready);
endinterface

FILE: src/wtt_out_if.sv
interface wtt_out_if #(
    parameter int COORD_BITS = wtt_pkg::COORD_BITS_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      target_x;
    logic signed [COORD_BITS-1:0]      target_y;
    logic [wtt_pkg::INDEX_W-1:0]       target_index;
    logic                              first_fix;
    logic                              external;

    modport source (output valid, target_x, target_y, target_index, first_fix, external,
                    input ready);
    modport sink (input valid, target_x, target_y, target_index, first_fix, external,
                  output ready);
endinterface

FILE: src/wtt_ram.sv
module wtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/wtt_dist.sv
module wtt_dist #(
    parameter int AW         = 10,
    parameter int COORD_BITS = wtt_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wtt_pkg::t_tag                i_tag,
    input  logic [AW-1:0]                i_idx,
    input  logic signed [COORD_BITS-1:0] i_wx,
    input  logic signed [COORD_BITS-1:0] i_wy,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output wtt_pkg::t_tag                o_tag,
    output logic [AW-1:0]                o_idx,
    output logic [2*COORD_BITS:0]        o_dist
);
    localparam int MW = COORD_BITS;
    localparam int SW = 2 * COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 1;

    logic signed [MW:0] dx;
    logic signed [MW:0] dy;
    logic [MW-1:0]      n_mx;
    logic [MW-1:0]      n_my;
    logic [SW-1:0]      n_sqx;
    logic [SW-1:0]      n_sqy;

    wtt_pkg::t_tag r_s1_tag, r_s2_tag, r_s3_tag;
    logic [AW-1:0] r_s1_idx, r_s2_idx, r_s3_idx;
    logic [MW-1:0] r_mx, r_my;
    logic [SW-1:0] r_sqx, r_sqy;
    logic [DW-1:0] r_dist;

    // The magnitude of a difference of two coordinates always fits MW bits.
    always_comb begin
        dx    = (MW + 1)'(i_px) - (MW + 1)'(i_wx);
        dy    = (MW + 1)'(i_py) - (MW + 1)'(i_wy);
        n_mx  = MW'(dx[MW] ? -dx : dx);
        n_my  = MW'(dy[MW] ? -dy : dy);
        n_sqx = {{MW{1'b0}}, r_mx} * {{MW{1'b0}}, r_mx};
        n_sqy = {{MW{1'b0}}, r_my} * {{MW{1'b0}}, r_my};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_tag <= '0;
        end else begin
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
        end
        r_s1_idx <= i_idx;
        r_s2_idx <= r_s1_idx;
        r_s3_idx <= r_s2_idx;
        r_mx     <= n_mx;
        r_my     <= n_my;
        r_sqx    <= n_sqx;
        r_sqy    <= n_sqy;
        r_dist   <= DW'(r_sqx) + DW'(r_sqy);
    end

    assign o_tag  = r_s3_tag;
    assign o_idx  = r_s3_idx;
    assign o_dist = r_dist;
endmodule

FILE: src/waypoint_target_tracker_top.sv
// Waypoint target tracker with a look-ahead point search.
// Items arrive on i_req. An item with mode 0 writes one waypoint (pos_x, pos_y) into the
// path store at point_index; it is taken when idle and gives no result. An item with
// mode 1 is a pose update and gives exactly one result item on o_rsp: the target waypoint,
// its path index and the first_fix and external flags.
// The configuration port writes one register per cycle while i_cfg_we is high, indexed as
// path mode, path length, look-ahead, radius, external x, external y.
// A pose update in interpolated mode scans its search window one waypoint per cycle out of
// the path store RAM; the first update after reset scans the whole path. Later updates scan
// at most twice the look-ahead plus one points. Key-incremental updates scan only the
// tracked waypoint, and their first fix takes waypoint 0 with no scan; external-target
// updates read no waypoint. The single read port of the path store sets the scan rate,
// and one item is worked on at a time.
// The result sits in an output register. While the receiver stalls, the block still takes
// waypoint writes; a further pose update waits in its last step until the register frees.
// Reset clears the tracked index, its valid flag, the output valid and the configuration,
// but for a path length of one. The path store is not cleared: entries read before they
// were written give undefined coordinates.
module waypoint_target_tracker_top #(
    parameter int MAX_POINTS = wtt_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = wtt_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wtt_in_if.sink                           i_req,
    wtt_out_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [wtt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wtt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int EW = AW + 11;
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int CW = (DW > 32) ? DW : 32;
    localparam int IW = wtt_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_FIN,
        S_DONE
    } t_state;

    // Kind of pose update: interpolated or key-incremental, first fix or tracking.
    typedef enum logic [1:0] {
        OP_NEAR_FIRST,
        OP_NEAR,
        OP_KEY,
        OP_KEY_FIRST
    } t_op;

    // Configuration registers.
    logic [1:0]                        r_path_mode;
    logic [10:0]                       r_path_points;
    logic [8:0]                        r_lookahead;
    logic [15:0]                       r_radius;
    logic signed [wtt_pkg::EXT_W-1:0]  r_ext_x;
    logic signed [wtt_pkg::EXT_W-1:0]  r_ext_y;
    logic [31:0]                       r_r2;

    // Sequencer state.
    t_state                       r_state;
    t_op                          r_op;
    logic                         r_idx_valid;
    logic [AW-1:0]                r_track;
    logic [AW-1:0]                r_last;
    logic [AW-1:0]                r_from;
    logic [AW-1:0]                r_end;
    logic [AW-1:0]                r_addr;
    logic [AW-1:0]                r_tgt;
    logic                         r_first;
    logic                         r_ext_sel;
    logic                         r_hit;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic [DW-1:0]                r_best_d;
    logic [AW-1:0]                r_best_idx;
    wtt_pkg::t_tag                r_rd_tag;
    logic [AW-1:0]                r_rd_idx;

    // Output register.
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x;
    logic signed [COORD_BITS-1:0] r_out_y;
    logic [IW-1:0]                r_out_idx;
    logic                         r_out_first;
    logic                         r_out_ext;

    // Combinational helpers.
    logic                         accept;
    logic                         is_pose;
    logic                         ram_we;
    logic                         ram_re;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [2*COORD_BITS-1:0]      ram_rdata;
    logic [AW-1:0]                cfg_last;
    logic [AW-1:0]                clamp_track;
    logic [EW-1:0]                span;
    logic [EW-1:0]                sum_la;
    logic [EW-1:0]                tgt_ext;
    logic [AW-1:0]                setup_end;
    logic [AW-1:0]                near_tgt;
    logic [AW-1:0]                key_next;
    logic [AW-1:0]                fin_tgt;
    wtt_pkg::t_tag                iss_tag;
    wtt_pkg::t_tag                d_tag;
    logic [AW-1:0]                d_idx;
    logic [DW-1:0]                d_dist;
    logic                         take;
    logic                         key_le;
    logic [AW-1:0]                n_best_idx;
    logic                         out_free;
    logic signed [COORD_BITS-1:0] ext_x_c;
    logic signed [COORD_BITS-1:0] ext_y_c;

    assign accept  = i_req.valid && i_req.ready;
    assign is_pose = (i_req.mode == wtt_pkg::MODE_POSE);
    assign i_req.ready = (r_state == S_IDLE);

    // Waypoint writes beyond the store are dropped.
    assign ram_we    = accept && !is_pose && (32'(i_req.point_index) < MAX_POINTS);
    assign ram_waddr = AW'(32'(i_req.point_index));
    assign ram_re    = (r_state == S_SCAN) || (r_state == S_FIN);
    assign ram_raddr = (r_state == S_FIN) ? fin_tgt : r_addr;

    wtt_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_POINTS)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_req.pos_x, i_req.pos_y}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Each scanned waypoint carries its index and scan-boundary flags.
    always_comb begin
        iss_tag.valid = (r_state == S_SCAN);
        iss_tag.first = (r_addr == r_from);
        iss_tag.last  = (r_addr == r_end);
    end

    wtt_dist #(
        .AW         (AW),
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_idx   (r_rd_idx),
        .i_wx    (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
        .i_wy    (ram_rdata[COORD_BITS-1:0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_tag   (d_tag),
        .o_idx   (d_idx),
        .o_dist  (d_dist)
    );

    always_comb begin
        // Last usable point: a length of zero counts as one, a length past the store
        // saturates at the store size.
        if (r_path_points == '0) begin
            cfg_last = '0;
        end else if (32'(r_path_points) > MAX_POINTS) begin
            cfg_last = AW'(MAX_POINTS - 1);
        end else begin
            cfg_last = AW'(32'(r_path_points) - 32'd1);
        end
        clamp_track = (r_track > cfg_last) ? cfg_last : r_track;

        // Window end: the whole path, the look-ahead span, or the start point alone.
        span = EW'(r_from) + (EW'(r_lookahead) << 1);
        case (r_op)
            OP_NEAR_FIRST: setup_end = r_last;
            OP_NEAR:       setup_end = (span > EW'(r_last)) ? r_last : span[AW-1:0];
            default:       setup_end = r_from;
        endcase

        // Target selection once the scan result is known.
        sum_la   = EW'(r_track) + EW'(r_lookahead);
        near_tgt = (sum_la > EW'(r_last)) ? r_last : sum_la[AW-1:0];
        key_next = (r_from == r_last) ? r_from : r_from + AW'(1);
        unique case (r_op)
            OP_NEAR_FIRST: fin_tgt = r_track;
            OP_NEAR:       fin_tgt = near_tgt;
            OP_KEY:        fin_tgt = r_hit ? key_next : r_from;
            OP_KEY_FIRST:  fin_tgt = '0;
            default:       fin_tgt = '0;
        endcase

        // Running minimum: the first strictly smaller distance wins.
        take       = d_tag.valid && (d_tag.first || (d_dist < r_best_d));
        n_best_idx = take ? d_idx : r_best_idx;
        key_le     = (CW'(d_dist) <= CW'(r_r2));

        out_free = !r_out_valid || o_rsp.ready;
        ext_x_c  = COORD_BITS'(32'(r_ext_x));
        ext_y_c  = COORD_BITS'(32'(r_ext_y));
        tgt_ext  = EW'(r_tgt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx_valid   <= 1'b0;
            r_track       <= '0;
            r_out_valid   <= 1'b0;
            r_rd_tag      <= '0;
            r_path_mode   <= wtt_pkg::PM_INTERP;
            r_path_points <= 11'd1;
            r_lookahead   <= '0;
            r_radius      <= '0;
            r_ext_x       <= '0;
            r_ext_y       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (wtt_pkg::t_cfg_reg'(i_cfg_idx))
                    wtt_pkg::CFG_PATH_MODE:   r_path_mode   <= i_cfg_data[1:0];
                    wtt_pkg::CFG_PATH_POINTS: r_path_points <= i_cfg_data[10:0];
                    wtt_pkg::CFG_LOOKAHEAD:   r_lookahead   <= i_cfg_data[8:0];
                    wtt_pkg::CFG_RADIUS:      r_radius      <= i_cfg_data;
                    wtt_pkg::CFG_EXT_X:       r_ext_x       <= i_cfg_data;
                    wtt_pkg::CFG_EXT_Y:       r_ext_y       <= i_cfg_data;
                    default: ;
                endcase
            end

            r_rd_tag <= iss_tag;
            r_rd_idx <= r_addr;

            if (take) begin
                r_best_d   <= d_dist;
                r_best_idx <= d_idx;
            end
            if (d_tag.valid && d_tag.last) begin
                r_hit <= key_le;
            end

            // In the done state the output register is handled below.
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && is_pose) begin
                        r_px <= i_req.pos_x;
                        r_py <= i_req.pos_y;
                        if (r_path_mode == wtt_pkg::PM_INTERP ||
                            r_path_mode == wtt_pkg::PM_KEY) begin
                            r_ext_sel <= 1'b0;
                            r_last    <= cfg_last;
                            r_from    <= r_idx_valid ? clamp_track : '0;
                            if (r_path_mode == wtt_pkg::PM_INTERP) begin
                                r_op <= r_idx_valid ? OP_NEAR : OP_NEAR_FIRST;
                            end else begin
                                r_op <= r_idx_valid ? OP_KEY : OP_KEY_FIRST;
                            end
                            r_state <= S_SETUP;
                        end else begin
                            r_ext_sel <= 1'b1;
                            r_state   <= S_DONE;
                        end
                    end
                end
                S_SETUP: begin
                    r_end   <= setup_end;
                    r_addr  <= r_from;
                    r_state <= (r_op == OP_KEY_FIRST) ? S_FIN : S_SCAN;
                end
                S_SCAN: begin
                    if (r_addr == r_end) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (d_tag.valid && d_tag.last) begin
                        if (r_op == OP_NEAR_FIRST || r_op == OP_NEAR) begin
                            r_track <= n_best_idx;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // The target read goes out now; its data is ready in the next state.
                    if (r_op == OP_KEY || r_op == OP_KEY_FIRST) begin
                        r_track <= fin_tgt;
                    end
                    r_idx_valid <= 1'b1;
                    r_tgt       <= fin_tgt;
                    r_first     <= (r_op == OP_NEAR_FIRST) || (r_op == OP_KEY_FIRST);
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_ext_sel ? ext_x_c
                                                 : ram_rdata[2*COORD_BITS-1:COORD_BITS];
                        r_out_y     <= r_ext_sel ? ext_y_c : ram_rdata[COORD_BITS-1:0];
                        r_out_idx   <= r_ext_sel ? '0 : tgt_ext[IW-1:0];
                        r_out_first <= r_ext_sel ? 1'b0 : r_first;
                        r_out_ext   <= r_ext_sel;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        // The radius square is registered from the radius register, well before any use.
        r_r2 <= {16'd0, r_radius} * {16'd0, r_radius};
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.target_x     = r_out_x;
    assign o_rsp.target_y     = r_out_y;
    assign o_rsp.target_index = r_out_idx;
    assign o_rsp.first_fix    = r_out_first;
    assign o_rsp.external     = r_out_ext;

    // The end of a scan only reaches the minimum logic while the sequencer waits for it.
    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_tag.valid && d_tag.last) |-> (r_state == S_DRAIN))
        else $error("scan end seen outside the drain state");

    // Waypoint writes never share a cycle with a path store read.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("path store written during a read");

    // Scan addresses stay inside the search window.
    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_addr <= r_end) && (r_from <= r_addr)))
        else $error("scan address outside the window");

    // After a path target is chosen the tracked index is valid and inside the path.
    a_track_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_idx_valid && (r_track <= r_last)))
        else $error("tracked index not valid or beyond the path");

    a_track_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_ext_sel) |-> (r_tgt <= r_last))
        else $error("target index beyond the last point");

endmodule

FILE: sim/waypoint_target_tracker_checker.sv
module waypoint_target_tracker_checker
    import wtt_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wtt_in_if                     i_req,
    wtt_out_if                    i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef longint unsigned dist_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [INDEX_W-1:0]           index;
        logic                         first_fix;
        logic                         external;
    } target_t;

    // Shadow of the path store, the tracked waypoint and the registers.
    logic signed [COORD_BITS-1:0] way_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] way_y [MAX_POINTS];
    int unsigned                  track_idx;
    bit                           track_ok;
    logic [1:0]                   cfg_mode;
    logic [10:0]                  cfg_points;
    logic [8:0]                   cfg_look;
    logic [15:0]                  cfg_radius;
    logic signed [COORD_BITS-1:0] cfg_ext_x;
    logic signed [COORD_BITS-1:0] cfg_ext_y;

    target_t targets_due [$];
    int      mismatches;

    assign o_fail_count = mismatches;

    function automatic dist_t sq_dist(int unsigned i, logic signed [COORD_BITS-1:0] px,
                                      logic signed [COORD_BITS-1:0] py);
        longint dx;
        longint dy;
        dx = longint'(way_x[i]) - longint'(px);
        dy = longint'(way_y[i]) - longint'(py);
        return dist_t'(dx * dx) + dist_t'(dy * dy);
    endfunction

    // Nearest waypoint in [lo, hi]; the first one wins a tie.
    function automatic int unsigned nearest_point(int unsigned lo, int unsigned hi,
                                                  logic signed [COORD_BITS-1:0] px,
                                                  logic signed [COORD_BITS-1:0] py);
        int unsigned best;
        int unsigned i;
        dist_t       best_d;
        dist_t       d;
        best   = lo;
        best_d = sq_dist(lo, px, py);
        for (i = lo + 1; i <= hi; i++) begin
            d = sq_dist(i, px, py);
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        return best;
    endfunction

    function automatic target_t predict_target(logic signed [COORD_BITS-1:0] px,
                                               logic signed [COORD_BITS-1:0] py);
        target_t     t;
        int unsigned n;
        int unsigned last;
        int unsigned stop;
        int unsigned tgt;
        dist_t       r2;
        t = '0;
        if (cfg_mode >= PM_EXT) begin
            t.x        = cfg_ext_x;
            t.y        = cfg_ext_y;
            t.external = 1'b1;
            return t;
        end
        n = (cfg_points == 0) ? 1 : int'(cfg_points);
        if (n > MAX_POINTS) n = MAX_POINTS;
        if (!track_ok) begin
            track_idx   = (cfg_mode == PM_INTERP) ? nearest_point(0, n - 1, px, py) : 0;
            track_ok    = 1'b1;
            t.first_fix = 1'b1;
            tgt         = track_idx;
        end else begin
            last = (track_idx > n - 1) ? n - 1 : track_idx;
            if (cfg_mode == PM_INTERP) begin
                stop = last + 2 * cfg_look;
                if (stop > n - 1) stop = n - 1;
                track_idx = nearest_point(last, stop, px, py);
                tgt = track_idx + cfg_look;
                if (tgt > n - 1) tgt = n - 1;
            end else begin
                r2 = dist_t'(cfg_radius) * dist_t'(cfg_radius);
                if (sq_dist(last, px, py) <= r2) begin
                    last = last + 1;
                    if (last > n - 1) last = n - 1;
                end
                track_idx = last;
                tgt       = last;
            end
        end
        t.x     = way_x[tgt];
        t.y     = way_y[tgt];
        t.index = INDEX_W'(tgt);
        return t;
    endfunction

    always @(posedge i_clk) begin
        target_t got;
        target_t want;
        if (!i_rst_n) begin
            track_idx  = 0;
            track_ok   = 1'b0;
            cfg_mode   = PM_INTERP;
            cfg_points = 11'd1;
            cfg_look   = '0;
            cfg_radius = '0;
            cfg_ext_x  = '0;
            cfg_ext_y  = '0;
            targets_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PATH_MODE:   cfg_mode   = i_cfg_data[1:0];
                    CFG_PATH_POINTS: cfg_points = i_cfg_data[10:0];
                    CFG_LOOKAHEAD:   cfg_look   = i_cfg_data[8:0];
                    CFG_RADIUS:      cfg_radius = i_cfg_data[15:0];
                    CFG_EXT_X:       cfg_ext_x  = COORD_BITS'(signed'(i_cfg_data));
                    CFG_EXT_Y:       cfg_ext_y  = COORD_BITS'(signed'(i_cfg_data));
                    default: ;
                endcase
            end

            if (i_req.valid && i_req.ready) begin
                if (i_req.mode == MODE_WRITE) begin
                    if (int'(i_req.point_index) < MAX_POINTS) begin
                        way_x[i_req.point_index] = i_req.pos_x;
                        way_y[i_req.point_index] = i_req.pos_y;
                    end
                end else begin
                    want        = predict_target(i_req.pos_x, i_req.pos_y);
                    targets_due = {targets_due, want};
                end
            end

            if (i_rsp.valid && i_rsp.ready) begin
                got.x         = i_rsp.target_x;
                got.y         = i_rsp.target_y;
                got.index     = i_rsp.target_index;
                got.first_fix = i_rsp.first_fix;
                got.external  = i_rsp.external;
                if (targets_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] target item with no pose waiting: x=%0d y=%0d index=%0d",
                                 $time, got.x, got.y, got.index);
                end else begin
                    want = targets_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"[%0t] target mismatch: expected x=%0d y=%0d index=%0d ",
                                      "first_fix=%0b external=%0b, got x=%0d y=%0d index=%0d ",
                                      "first_fix=%0b external=%0b"},
                                     $time, want.x, want.y, want.index, want.first_fix,
                                     want.external, got.x, got.y, got.index, got.first_fix,
                                     got.external);
                    end
                end
            end
            o_pending <= targets_due.size();
        end
    end

endmodule

FILE: sim/waypoint_target_tracker_top_tb.sv
module waypoint_target_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtt_pkg::*;

    localparam int MAX_POINTS    = MAX_POINTS_DEF;
    localparam int COORD_BITS    = COORD_BITS_DEF;
    localparam int ITEM_GOAL     = 570;
    localparam int SETTLE_CYCLES = 16;

    // Path mode code 3 has no meaning of its own; the block must treat it like the
    // external-target mode.
    localparam logic [1:0] PM_UNDEF = PM_EXT | PM_KEY;

    // Register index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // Shapes of the waypoint sets written into the path store.
    typedef enum {PATH_SCATTER, PATH_LINE, PATH_SAME} path_style_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;

    wtt_in_if  #(.COORD_BITS(COORD_BITS)) req_if ();
    wtt_out_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

    waypoint_target_tracker_top #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // The checker watches both channels and the configuration port, predicts every
    // target item and compares. It tells the stimulus how many targets are still due.
    waypoint_target_tracker_checker #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stimulus-side picture of the path store. It only serves to aim poses at the path
    // and to make sure that no pose ever makes the block read an entry never written.
    logic signed [COORD_BITS-1:0] mirror_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] mirror_y [MAX_POINTS];
    bit                           stored   [MAX_POINTS];

    // Shape of the waypoints that the current phase writes.
    path_style_t style;
    int          base_x;
    int          base_y;
    int          step_x;
    int          step_y;

    int unsigned cur_n;       // path length as the block sees it
    int unsigned walk_idx;    // waypoint that the simulated robot is passing
    bit          gap_on;
    bit          stall_on;

    // The receiver stalls in random bursts while stall_on is set. Each pass of the
    // loop makes at most one assignment to ready per clock edge.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    // A hung block must not hold the run forever. The limit covers the slowest correct
    // run: every pose scanning the whole store, with the longest gaps and stalls.
    initial begin
        #150ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void next_point(int unsigned i, output logic signed [COORD_BITS-1:0] x,
                                       output logic signed [COORD_BITS-1:0] y);
        case (style)
            PATH_SCATTER: begin
                x = COORD_BITS'($urandom);
                y = COORD_BITS'($urandom);
            end
            PATH_LINE: begin
                x = COORD_BITS'(base_x + int'(i) * step_x + int'($urandom_range(0, 6)) - 3);
                y = COORD_BITS'(base_y + int'(i) * step_y + int'($urandom_range(0, 6)) - 3);
            end
            default: begin
                x = COORD_BITS'(base_x);
                y = COORD_BITS'(base_y);
            end
        endcase
    endfunction

    // Offers one item and returns at the clock edge that accepts it, with valid still
    // high, so that a following item can go out back to back. A random gap, with noise
    // on the payload, may come first.
    task automatic drive_item(logic m, logic [INDEX_W-1:0] idx,
                              logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y);
        int unsigned hold;
        if (gap_on && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 13);
            req_if.valid       <= 1'b0;
            req_if.mode        <= 1'($urandom);
            req_if.point_index <= INDEX_W'($urandom);
            req_if.pos_x       <= COORD_BITS'($urandom);
            req_if.pos_y       <= COORD_BITS'($urandom);
            repeat (hold) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= m;
        req_if.point_index <= idx;
        req_if.pos_x       <= x;
        req_if.pos_y       <= y;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic put_waypoint(int unsigned i, logic signed [COORD_BITS-1:0] x,
                                logic signed [COORD_BITS-1:0] y);
        drive_item(MODE_WRITE, INDEX_W'(i), x, y);
        mirror_x[i] = x;
        mirror_y[i] = y;
        stored[i]   = 1'b1;
    endtask

    task automatic send_pose(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y);
        // The index field means nothing for a pose; random bits check that it is ignored.
        drive_item(MODE_POSE, INDEX_W'($urandom), x, y);
    endtask

    task automatic send_pose_near(int unsigned i, int spread);
        send_pose(COORD_BITS'(int'(mirror_x[i]) + int'($urandom_range(0, 2 * spread)) - spread),
                  COORD_BITS'(int'(mirror_y[i]) + int'($urandom_range(0, 2 * spread)) - spread));
    endtask

    task automatic rewrite_path();
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        for (int unsigned i = 0; i < cur_n; i++) begin
            next_point(i, x, y);
            put_waypoint(i, x, y);
        end
    endtask

    // Holds the sender back until every pose has its target item, then lets the block
    // run dry. Waypoint writes give no item, so the extra cycles cover the last of them.
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes leave cfg_we high so that several registers go out on consecutive edges.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Sets up one phase on an idle block. With junk set, the data bits above a narrow
    // register carry random values that the block has to drop.
    task automatic program_path(logic [1:0] pm, logic [10:0] points, logic [8:0] look,
                                logic [15:0] radius, logic [15:0] ex, logic [15:0] ey,
                                bit junk);
        logic [CFG_DATA_W-1:0]        noise;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        settle();
        noise = junk ? CFG_DATA_W'($urandom) : '0;
        write_reg(CFG_PATH_MODE,   {noise[15:2], pm});
        write_reg(CFG_PATH_POINTS, {noise[15:11], points});
        write_reg(CFG_LOOKAHEAD,   {noise[15:9], look});
        write_reg(CFG_RADIUS,      radius);
        write_reg(CFG_EXT_X,       ex);
        write_reg(CFG_EXT_Y,       ey);
        cfg_we <= 1'b0;
        // A length of zero counts as one point, anything above the store as a full store.
        cur_n = (points == 0) ? 1 : int'(points);
        if (cur_n > MAX_POINTS) cur_n = MAX_POINTS;
        walk_idx = 0;
        // Every entry that a pose of this phase may reach must hold a waypoint.
        for (int unsigned i = 0; i < cur_n; i++) begin
            if (!stored[i]) begin
                next_point(i, x, y);
                put_waypoint(i, x, y);
            end
        end
    endtask

    initial begin
        int unsigned                  phase;
        int unsigned                  phase_len;
        int unsigned                  random_items;
        int unsigned                  r;
        int unsigned                  idx;
        int                           spread;
        logic [1:0]                   pm;
        logic [10:0]                  pts;
        logic [8:0]                   look;
        logic [15:0]                  rad;
        bit                           junk;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_PATH_MODE;
        cfg_data           <= '0;
        req_if.valid       <= 1'b0;
        req_if.mode        <= MODE_WRITE;
        req_if.point_index <= '0;
        req_if.pos_x       <= '0;
        req_if.pos_y       <= '0;
        gap_on   = 1'b1;
        stall_on = 1'b1;
        style    = PATH_LINE;
        base_x   = -2000;
        base_y   = 1500;
        step_x   = 250;
        step_y   = -120;
        cur_n    = 1;
        walk_idx = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The external target comes first, while no waypoint is tracked
        // yet: it must leave the tracking state alone, so the first real fix is still
        // to come. The extreme corners of the coordinate range are used as targets.
        program_path(PM_EXT, 11'd16, 9'd0, 16'd0, 16'h7FFF, 16'h8000, 1'b0);
        send_pose(16'sh8000, 16'sh7FFF);
        send_pose(16'sh7FFF, 16'sh8000);
        program_path(PM_UNDEF, 11'd16, 9'd5, 16'd9, 16'h8000, 16'h7FFF, 1'b0);
        send_pose(16'sh0000, 16'sh0000);

        // The first interpolated pose searches the whole path for the nearest waypoint.
        // Later ones search the window that starts at the tracked one.
        program_path(PM_INTERP, 11'd16, 9'd2, 16'd0, 16'h0000, 16'h0000, 1'b0);
        send_pose_near(9, 40);
        send_pose(16'sh8000, 16'sh8000);
        put_waypoint(15, 16'sh7FFF, 16'sh7FFF);
        put_waypoint(0, 16'sh8000, 16'sh8000);
        send_pose(16'sh7FFF, 16'sh7FFF);
        send_pose(16'sh8000, 16'sh8000);

        // A path length of zero is taken as one point; the tracked index falls back to
        // the only waypoint even with the largest look-ahead.
        program_path(PM_INTERP, 11'd0, 9'd511, 16'd0, 16'h0000, 16'h0000, 1'b0);
        send_pose(16'sh1234, -16'sh0321);

        settle();
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;

        // Key-incremental mode with a radius of zero: only a pose exactly on the tracked
        // waypoint moves on, one off by a single unit does not.
        program_path(PM_KEY, 11'd16, 9'd0, 16'd0, 16'h0000, 16'h0000, 1'b0);
        send_pose_near(0, 0);
        send_pose(COORD_BITS'(int'(mirror_x[1]) + 1), mirror_y[1]);
        send_pose_near(1, 0);
        program_path(PM_KEY, 11'd16, 9'd0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        send_pose_near(2, 100);

        // Shrinking the path below the tracked index clamps it to the last point, and
        // an advance past the end stays on the last point.
        program_path(PM_KEY, 11'd2, 9'd0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        send_pose_near(1, 0);

        // All waypoints on one spot: every distance ties and the first one must win.
        style  = PATH_SAME;
        base_x = -700;
        base_y = 300;
        program_path(PM_INTERP, 11'd12, 9'd3, 16'd0, 16'h0000, 16'h0000, 1'b0);
        rewrite_path();
        send_pose(COORD_BITS'($urandom), COORD_BITS'($urandom));
        send_pose(COORD_BITS'($urandom), COORD_BITS'($urandom));

        // Random part: phases of random settings. Most poses follow the path the way a
        // robot would, so the tracked index travels along it; the rest are poses
        // anywhere and waypoint rewrites, some of them outside the path in use.
        phase        = 0;
        random_items = 0;
        while (random_items < ITEM_GOAL) begin
            phase++;
            if (random_items >= ITEM_GOAL * 85 / 100) begin
                gap_on   = 1'b0;
                stall_on = 1'b0;
            end else begin
                gap_on   = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end

            r = $urandom_range(0, 99);
            pm = (r < 45) ? PM_INTERP : (r < 80) ? PM_KEY : (r < 92) ? PM_EXT : PM_UNDEF;
            r = $urandom_range(0, 99);
            pts = (r < 5) ? 11'd0 : (r < 15) ? 11'd1 : 11'($urandom_range(2, 48));
            r = $urandom_range(0, 99);
            look = (r < 35) ? 9'($urandom_range(0, 3)) : (r < 70) ? 9'($urandom_range(4, 16)) :
                   (r < 85) ? 9'd511 : 9'($urandom_range(0, 511));
            r = $urandom_range(0, 99);
            rad = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF :
                  (r < 80) ? 16'($urandom_range(0, 600)) : 16'($urandom);
            junk      = ($urandom_range(0, 1) == 1);
            phase_len = $urandom_range(12, 36);

            r = $urandom_range(0, 99);
            style  = (r < 20) ? PATH_SCATTER : (r < 85) ? PATH_LINE : PATH_SAME;
            base_x = int'($urandom_range(0, 65535)) - 32768;
            base_y = int'($urandom_range(0, 65535)) - 32768;
            step_x = int'($urandom_range(0, 1400)) - 700;
            step_y = int'($urandom_range(0, 1400)) - 700;
            spread = int'($urandom_range(0, 400));

            // Two phases use the whole store: an oversized length that saturates, with
            // the widest search window, then key-incremental mode on the full path.
            // The interpolated phase scans long windows; both get only a few items.
            if (phase == 4) begin
                pm = PM_INTERP;
                pts = 11'd2047;
                look = 9'd511;
                style = PATH_LINE;
                step_x = int'($urandom_range(0, 60)) - 30;
                step_y = int'($urandom_range(0, 60)) - 30;
                phase_len = 8;
            end else if (phase == 5) begin
                pm = PM_KEY;
                pts = 11'd1024;
                phase_len = 10;
            end

            program_path(pm, pts, look, rad, 16'($urandom), 16'($urandom), junk);
            if (phase > 5 && $urandom_range(0, 99) < 40) rewrite_path();

            for (int unsigned k = 0; k < phase_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    if ($urandom_range(0, 9) == 0) walk_idx = $urandom_range(0, cur_n - 1);
                    else walk_idx = walk_idx + $urandom_range(0, 2);
                    if (walk_idx > cur_n - 1) walk_idx = cur_n - 1;
                    send_pose_near(walk_idx, spread);
                end else if (r < 70) begin
                    send_pose(COORD_BITS'($urandom), COORD_BITS'($urandom));
                end else if (r < 90) begin
                    idx = $urandom_range(0, cur_n - 1);
                    next_point(idx, x, y);
                    put_waypoint(idx, x, y);
                end else begin
                    put_waypoint($urandom_range(0, MAX_POINTS - 1), COORD_BITS'($urandom),
                                 COORD_BITS'($urandom));
                end
                random_items++;
                // Now and then the sender holds off until every target has come back.
                if ($urandom_range(0, 49) == 0) settle();
            end
        end

        // Drain: every pose must have its target item, and nothing may follow.
        settle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
